### rtl/assert_macros.svh
// Assertion helpers; clk and rst are taken from the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle.
`define CHK_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("check failed");

// Consequent checked in the next cycle.
`define CHK_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("check failed");

`endif

### rtl/ssfb_pkg.sv
package ssfb_pkg;

  localparam int STORE_DEPTH     = 16;
  localparam int FRAME_BYTES_DEF = 16;
  localparam int CFG_DATA_W      = 3;

  localparam logic [7:0] CMD_MODE     = 8'h40;
  localparam logic [7:0] CMD_ADDR     = 8'hC0;
  localparam logic [7:0] CMD_DISP_OFF = 8'h80;
  localparam logic [7:0] CMD_DISP_ON  = 8'h88;
  localparam logic [3:0] MAX_DIGIT    = 4'd11;
  localparam logic [2:0] LAST_SEG     = 3'd6;

  typedef enum logic [1:0] {
    OP_SEG   = 2'd0,
    OP_CHAR  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_FLUSH = 2'd3
  } op_t;

  typedef enum logic {
    CFG_BRIGHTNESS = 1'b0,
    CFG_DISPLAY_ON = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SEG_RD,
    ST_SEG_WR,
    ST_HDR_MODE,
    ST_HDR_ADDR,
    ST_DATA,
    ST_DISP
  } state_t;

  typedef enum logic [1:0] {
    ADDR_SEG,
    ADDR_CNT,
    ADDR_NEXT
  } addr_sel_t;

  typedef enum logic [1:0] {
    BYTE_MODE,
    BYTE_ADDR,
    BYTE_FRAME,
    BYTE_DISP
  } byte_sel_t;

  typedef struct packed {
    logic      load;
    logic      clear_frame;
    logic      mem_rd;
    logic      mem_wr;
    logic      cnt_clr;
    logic      cnt_inc;
    logic      emit;
    addr_sel_t addr_sel;
    byte_sel_t byte_sel;
  } ctrl_t;

  typedef struct packed {
    logic digit_ok;
    logic seg_last;
    logic cnt_last;
  } status_t;

  function automatic logic [6:0] font(input logic [7:0] ch);
    logic [6:0] f;
    unique case (ch)
      8'h30:   f = 7'h3F;
      8'h31:   f = 7'h06;
      8'h32:   f = 7'h5B;
      8'h33:   f = 7'h4F;
      8'h34:   f = 7'h66;
      8'h35:   f = 7'h6D;
      8'h36:   f = 7'h7D;
      8'h37:   f = 7'h07;
      8'h38:   f = 7'h7F;
      8'h39:   f = 7'h6F;
      default: f = 7'h00;
    endcase
    return f;
  endfunction

  function automatic logic [3:0] column(input logic [3:0] digit);
    logic [3:0] c;
    unique case (digit)
      4'd10:   c = 4'd12;
      4'd11:   c = 4'd13;
      default: c = digit;
    endcase
    return c;
  endfunction

endpackage

### rtl/ssfb_ram.sv
module ssfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### rtl/ssfb_ctrl.sv
module ssfb_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [1:0]        op,
  input  ssfb_pkg::status_t status,
  output ssfb_pkg::ctrl_t   ctrl,
  output logic              busy
);

  ssfb_pkg::state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ssfb_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ssfb_pkg::ST_IDLE: begin
        if (start) begin
          if (op == ssfb_pkg::OP_SEG || op == ssfb_pkg::OP_CHAR) begin
            state_next = status.digit_ok ? ssfb_pkg::ST_SEG_RD : ssfb_pkg::ST_IDLE;
          end else begin
            state_next = ssfb_pkg::ST_HDR_MODE;
          end
        end
      end
      ssfb_pkg::ST_SEG_RD:   state_next = ssfb_pkg::ST_SEG_WR;
      ssfb_pkg::ST_SEG_WR: begin
        state_next = status.seg_last ? ssfb_pkg::ST_IDLE : ssfb_pkg::ST_SEG_RD;
      end
      ssfb_pkg::ST_HDR_MODE: state_next = ssfb_pkg::ST_HDR_ADDR;
      ssfb_pkg::ST_HDR_ADDR: state_next = ssfb_pkg::ST_DATA;
      ssfb_pkg::ST_DATA: begin
        state_next = status.cnt_last ? ssfb_pkg::ST_DISP : ssfb_pkg::ST_DATA;
      end
      ssfb_pkg::ST_DISP:     state_next = ssfb_pkg::ST_IDLE;
      default:               state_next = ssfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    ctrl = '0;
    ctrl.addr_sel = ssfb_pkg::ADDR_SEG;
    ctrl.byte_sel = ssfb_pkg::BYTE_FRAME;
    busy = 1'b1;
    unique case (state)
      ssfb_pkg::ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          ctrl.load        = 1'b1;
          ctrl.cnt_clr     = 1'b1;
          ctrl.clear_frame = (op == ssfb_pkg::OP_CLEAR);
        end
      end
      ssfb_pkg::ST_SEG_RD: begin
        ctrl.mem_rd = 1'b1;
      end
      ssfb_pkg::ST_SEG_WR: begin
        ctrl.mem_wr  = 1'b1;
        ctrl.cnt_inc = 1'b1;
      end
      ssfb_pkg::ST_HDR_MODE: begin
        ctrl.emit     = 1'b1;
        ctrl.byte_sel = ssfb_pkg::BYTE_MODE;
      end
      ssfb_pkg::ST_HDR_ADDR: begin
        ctrl.emit     = 1'b1;
        ctrl.byte_sel = ssfb_pkg::BYTE_ADDR;
        ctrl.mem_rd   = 1'b1;
        ctrl.addr_sel = ssfb_pkg::ADDR_CNT;
      end
      ssfb_pkg::ST_DATA: begin
        ctrl.emit     = 1'b1;
        ctrl.byte_sel = ssfb_pkg::BYTE_FRAME;
        ctrl.mem_rd   = 1'b1;
        ctrl.addr_sel = ssfb_pkg::ADDR_NEXT;
        ctrl.cnt_inc  = 1'b1;
      end
      ssfb_pkg::ST_DISP: begin
        ctrl.emit     = 1'b1;
        ctrl.byte_sel = ssfb_pkg::BYTE_DISP;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

endmodule

### rtl/ssfb_dp.sv
module ssfb_dp #(
  parameter int FRAME_BYTES = ssfb_pkg::FRAME_BYTES_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  ssfb_pkg::ctrl_t                     ctrl,
  output ssfb_pkg::status_t                   status,
  input  logic [1:0]                          op,
  input  logic [3:0]                          digit,
  input  logic [7:0]                          seg_bits,
  input  logic [7:0]                          char_code,
  input  logic                                cfg_we,
  input  logic                                cfg_index,
  input  logic [ssfb_pkg::CFG_DATA_W-1:0]     cfg_data,
  output logic [7:0]                          data_byte,
  output logic                                strobe_start,
  output logic                                last
);

  localparam int AW    = $clog2(ssfb_pkg::STORE_DEPTH);
  localparam int CNT_W = $clog2(FRAME_BYTES);

  logic [2:0]       brightness;
  logic             display_on;
  logic [6:0]       pat;
  logic             hi;
  logic [7:0]       mask;
  logic [CNT_W-1:0] cnt;
  logic [ssfb_pkg::STORE_DEPTH-1:0] valid;
  logic             rd_valid;
  logic [AW-1:0]    addr;
  logic [7:0]       rd_data;
  logic [7:0]       cur_byte;
  logic [7:0]       wdata;
  logic [3:0]       col;

  assign col = ssfb_pkg::column(digit);

  always_ff @(posedge clk) begin
    if (rst) begin
      brightness <= 3'd7;
      display_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ssfb_pkg::CFG_BRIGHTNESS: brightness <= cfg_data[2:0];
        ssfb_pkg::CFG_DISPLAY_ON: display_on <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      pat  <= (op == ssfb_pkg::OP_CHAR) ? ssfb_pkg::font(char_code) : seg_bits[6:0];
      hi   <= col[3];
      mask <= 8'd1 << col[2:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= '0;
    end else if (ctrl.cnt_clr) begin
      cnt <= '0;
    end else if (ctrl.cnt_inc) begin
      cnt <= cnt + CNT_W'(1);
    end
  end

  always_comb begin
    unique case (ctrl.addr_sel)
      ssfb_pkg::ADDR_SEG:  addr = AW'({cnt[2:0], hi});
      ssfb_pkg::ADDR_CNT:  addr = AW'(cnt);
      ssfb_pkg::ADDR_NEXT: addr = AW'(cnt) + AW'(1);
      default:             addr = AW'(cnt);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst || ctrl.clear_frame) begin
      valid <= '0;
    end else if (ctrl.mem_wr) begin
      valid[addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.mem_rd) begin
      rd_valid <= valid[addr];
    end
  end

  ssfb_ram #(
    .WIDTH (8),
    .DEPTH (ssfb_pkg::STORE_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ctrl.mem_wr),
    .waddr (addr),
    .wdata (wdata),
    .re    (ctrl.mem_rd),
    .raddr (addr),
    .rdata (rd_data)
  );

  // entries never written since reset or clear read as zero
  assign cur_byte = rd_valid ? rd_data : 8'h00;
  assign wdata    = pat[cnt[2:0]] ? (cur_byte | mask) : (cur_byte & ~mask);

  always_comb begin
    unique case (ctrl.byte_sel)
      ssfb_pkg::BYTE_MODE:  data_byte = ssfb_pkg::CMD_MODE;
      ssfb_pkg::BYTE_ADDR:  data_byte = ssfb_pkg::CMD_ADDR;
      ssfb_pkg::BYTE_FRAME: data_byte = cur_byte;
      ssfb_pkg::BYTE_DISP: begin
        data_byte = display_on ? (ssfb_pkg::CMD_DISP_ON | {5'd0, brightness})
                               : ssfb_pkg::CMD_DISP_OFF;
      end
      default:              data_byte = cur_byte;
    endcase
  end

  assign strobe_start = ctrl.byte_sel != ssfb_pkg::BYTE_FRAME;
  assign last         = ctrl.byte_sel == ssfb_pkg::BYTE_DISP;

  assign status.digit_ok = digit <= ssfb_pkg::MAX_DIGIT;
  assign status.seg_last = cnt[2:0] == ssfb_pkg::LAST_SEG;
  assign status.cnt_last = cnt == CNT_W'(FRAME_BYTES - 1);

endmodule

### rtl/seven_segment_scatter_framebuffer_top.sv
// Shadow frame for a serial seven-segment LED driver.
// Command channel: an operation is taken when start is high and busy is low.
//   op 0 writes a raw segment pattern to one digit, op 1 writes a character
//   ('0'-'9' shown, anything else blank), op 2 clears the frame and flushes,
//   op 3 flushes. Digits above 11 make writes a no-op.
// Writes produce no results and keep busy high through a read and a write
//   of the frame RAM for each of 7 segments; an out-of-range digit leaves
//   busy low.
// A flush produces FRAME_BYTES + 3 results on consecutive cycles starting the
//   cycle after the command: 0x40, 0xC0, the frame bytes, then the display
//   command. Busy stays high while those results are sent, so a new command
//   is taken only after the display command.
// Each result is valid for one cycle under result_valid; strobe_start marks
//   the first byte of each strobe group and last the display command. There
//   is no backpressure on results.
// Config: cfg_index 0 is brightness, 1 is display_on; cfg_ready is always
//   high. The user makes writes while busy is low; the block does not check.
// Reset clears the frame to zero, brightness to 7 and display_on to 1.
module seven_segment_scatter_framebuffer_top #(
  parameter int FRAME_BYTES = ssfb_pkg::FRAME_BYTES_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      op,
  input  logic [3:0]                      digit,
  input  logic [7:0]                      seg_bits,
  input  logic [7:0]                      char_code,
  output logic                            result_valid,
  output logic [7:0]                      data_byte,
  output logic                            strobe_start,
  output logic                            last,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic                            cfg_index,
  input  logic [ssfb_pkg::CFG_DATA_W-1:0] cfg_data
);

  `include "assert_macros.svh"

  ssfb_pkg::ctrl_t   ctrl;
  ssfb_pkg::status_t status;

  assign cfg_ready    = 1'b1;
  assign result_valid = ctrl.emit;

  ssfb_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .op     (op),
    .status (status),
    .ctrl   (ctrl),
    .busy   (busy)
  );

  ssfb_dp #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .ctrl         (ctrl),
    .status       (status),
    .op           (op),
    .digit        (digit),
    .seg_bits     (seg_bits),
    .char_code    (char_code),
    .cfg_we       (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .data_byte    (data_byte),
    .strobe_start (strobe_start),
    .last         (last)
  );

  `CHK_NEXT(a_flush_opens, start && !busy && (op == ssfb_pkg::OP_FLUSH || op == ssfb_pkg::OP_CLEAR), result_valid && strobe_start && (data_byte == ssfb_pkg::CMD_MODE))
  `CHK_NEXT(a_last_frees, result_valid && last, !busy && !result_valid)
  `CHK_NEXT(a_bad_digit_noop, start && !busy && (op == ssfb_pkg::OP_SEG || op == ssfb_pkg::OP_CHAR) && (digit > ssfb_pkg::MAX_DIGIT), !busy)
  `CHK_SAME(a_idle_quiet, !busy, !result_valid)

endmodule
